// ===== src/bmp_row_pixel_unpacker_defines.svh =====
// Assertion macros used by the checker file of the bitmap row unpacker.
// Depends on nothing; included by bare file name.
`ifndef BMP_ROW_PIXEL_UNPACKER_DEFINES_SVH
`define BMP_ROW_PIXEL_UNPACKER_DEFINES_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define BRPU_ASSERT_CLK(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("brpu assertion failed");

// Concurrent assertion on the block clock and reset.
`define BRPU_ASSERT(label, prop) `BRPU_ASSERT_CLK(label, clk, rst, prop)

`endif

// ===== src/brpu_pkg.sv =====
// Shared types, constants and decode functions of the bitmap row unpacker.
// Depends on nothing; used by every module of the block but brpu_ram.
package brpu_pkg;

  localparam int PALETTE_DEPTH  = 256;
  localparam int PAL_AW         = $clog2(PALETTE_DEPTH);
  localparam int PAL_W          = 24;
  localparam int MAX_ROW_PIXELS = 4096;
  localparam int COL_W          = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int EW             = COL_W + 1;

  localparam int FMT_W  = 3;
  localparam int ROW_W  = 13;
  localparam int SCR_W  = 3;
  localparam int IDX_W  = 2;
  localparam int CFG_DW = 13;

  // Pixel formats.
  localparam logic [FMT_W-1:0] FMT_PAL = 3'd0;
  localparam logic [FMT_W-1:0] FMT_565 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_555 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_24  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_32  = 3'd4;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_FORMAT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_SCREEN    = 2'd2;

  localparam logic [FMT_W-1:0] RST_FORMAT    = FMT_24;
  localparam logic [ROW_W-1:0] RST_ROW_WIDTH = 13'd640;
  localparam logic [SCR_W-1:0] RST_SCREEN    = 3'd4;

  localparam logic [15:0] MASK_565_R = 16'hf800;
  localparam logic [15:0] MASK_565_G = 16'h07e0;
  localparam logic [15:0] MASK_BLUE  = 16'h001f;
  localparam logic [15:0] MASK_555_R = 16'h7c00;
  localparam logic [15:0] MASK_555_G = 16'h03e0;

  typedef struct packed {
    logic [FMT_W-1:0] fmt;
    logic [ROW_W-1:0] row_width;
    logic [SCR_W-1:0] screen;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic [31:0] full;
    logic        last;
  } pix_t;

  function automatic logic [2:0] bytes_for_format(input logic [FMT_W-1:0] fmt);
    logic [2:0] n;
    unique case (fmt)
      FMT_PAL:          n = 3'd1;
      FMT_565, FMT_555: n = 3'd2;
      FMT_24:           n = 3'd3;
      FMT_32:           n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] screen_mask(input logic [SCR_W-1:0] scr);
    logic [31:0] m;
    unique case (scr)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] decode_pixel(input logic [FMT_W-1:0] fmt,
                                               input logic [31:0]      v,
                                               input logic [PAL_W-1:0] pal);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [31:0] w;
    r = (v[15:0] & MASK_565_R) >> 8;
    g = (v[15:0] & MASK_565_G) >> 3;
    b = (v[15:0] & MASK_BLUE) << 3;
    unique case (fmt)
      FMT_PAL: w = {8'd0, pal};
      FMT_565: w = {8'd0, r[7:0], g[7:0], b[7:0]};
      FMT_555: begin
        r = (v[15:0] & MASK_555_R) >> 7;
        g = (v[15:0] & MASK_555_G) >> 2;
        w = {8'd0, r[7:0], g[7:0], b[7:0]};
      end
      FMT_24:  w = {8'd0, v[23:0]};
      default: w = v;
    endcase
    return w;
  endfunction

endpackage

// ===== src/brpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the palette of the bitmap row unpacker.
module brpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/brpu_gather.sv =====
// Byte gathering, row padding skip and column tracking of the unpacker.
// Depends on brpu_pkg.
module brpu_gather (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  brpu_pkg::cfg_t cfg,
  output brpu_pkg::pix_t pix
);

  logic [1:0]                   byte_in_pixel, byte_in_pixel_next;
  logic [23:0]                  gathered_bytes, gathered_bytes_next;
  logic [brpu_pkg::COL_W-1:0]   pixel_column, pixel_column_next;
  logic [1:0]                   pad_left, pad_left_next;

  logic [2:0]                   bpp;
  logic [brpu_pkg::EW-1:0]      eff_width;
  logic [brpu_pkg::EW-1:0]      col_plus;
  logic [3:0]                   pad_prod;
  logic [4:0]                   shamt;

  assign bpp   = brpu_pkg::bytes_for_format(cfg.fmt);
  assign shamt = {byte_in_pixel, 3'b000};

  always_comb begin
    if (cfg.row_width == '0) begin
      eff_width = brpu_pkg::EW'(1);
    end else if (32'(cfg.row_width) > 32'(brpu_pkg::MAX_ROW_PIXELS)) begin
      eff_width = brpu_pkg::EW'(brpu_pkg::MAX_ROW_PIXELS);
    end else begin
      eff_width = brpu_pkg::EW'(cfg.row_width);
    end
  end

  assign col_plus = brpu_pkg::EW'(pixel_column) + brpu_pkg::EW'(1);
  // Only the low two bits of width times pixel size decide the padding.
  assign pad_prod = eff_width[1:0] * bpp[1:0];

  always_comb begin
    byte_in_pixel_next  = byte_in_pixel;
    gathered_bytes_next = gathered_bytes;
    pixel_column_next   = pixel_column;
    pad_left_next       = pad_left;
    pix.done            = 1'b0;
    pix.full            = {8'd0, gathered_bytes} | (32'(data_byte) << shamt);
    pix.last            = col_plus >= eff_width;
    if (take) begin
      if (pad_left != 2'd0) begin
        pad_left_next = pad_left - 2'd1;
      end else if (bpp != 3'd0) begin
        if (3'(byte_in_pixel) + 3'd1 < bpp) begin
          gathered_bytes_next = gathered_bytes | (24'(data_byte) << shamt);
          byte_in_pixel_next  = byte_in_pixel + 2'd1;
        end else begin
          pix.done            = 1'b1;
          byte_in_pixel_next  = 2'd0;
          gathered_bytes_next = 24'd0;
          if (pix.last) begin
            pixel_column_next = '0;
            pad_left_next     = 2'd0 - pad_prod[1:0];
          end else begin
            pixel_column_next = col_plus[brpu_pkg::COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_pixel  <= 2'd0;
      gathered_bytes <= 24'd0;
      pixel_column   <= '0;
      pad_left       <= 2'd0;
    end else begin
      byte_in_pixel  <= byte_in_pixel_next;
      gathered_bytes <= gathered_bytes_next;
      pixel_column   <= pixel_column_next;
      pad_left       <= pad_left_next;
    end
  end

endmodule

// ===== src/bmp_row_pixel_unpacker.sv =====
// Channel   Handshake           Payload
// in        in_valid/in_stall   mode, palette_index, palette_color, data_byte
// out       out_valid/out_stall pixel_word, last_in_row
// cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One input item per cycle is taken while in_stall is low. The last byte of a
// pixel moves it and its palette read into the decode stage, and the output
// register decodes it. Synchronous reset clears the row state and reloads the
// register defaults; the palette holds whatever was last written. in_stall
// rises only while a finished pixel is held at the output by out_stall and the
// decode stage is also full. Depends on brpu_pkg, brpu_gather and brpu_ram.
module bmp_row_pixel_unpacker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [7:0]                  palette_index,
  input  logic [23:0]                 palette_color,
  input  logic [7:0]                  data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 pixel_word,
  output logic                        last_in_row,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brpu_pkg::IDX_W-1:0]  cfg_index,
  input  logic [brpu_pkg::CFG_DW-1:0] cfg_data
);

  brpu_pkg::cfg_t cfg;
  brpu_pkg::pix_t pix;

  logic accept;
  logic out_adv;
  logic pal_we;
  logic [brpu_pkg::PAL_W-1:0] pal_rdata;

  // Decode stage.
  logic                         p1_valid;
  logic [31:0]                  p1_full;
  logic                         p1_last;
  logic [brpu_pkg::FMT_W-1:0]   p1_fmt;
  logic [brpu_pkg::SCR_W-1:0]   p1_screen;
  logic                         p1_pal_ok;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid || !out_stall;
  assign in_stall  = p1_valid && !out_adv;
  assign accept    = in_valid && !in_stall;
  assign pal_we    = accept && !mode && (9'(palette_index) < 9'(brpu_pkg::PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt       <= brpu_pkg::RST_FORMAT;
      cfg.row_width <= brpu_pkg::RST_ROW_WIDTH;
      cfg.screen    <= brpu_pkg::RST_SCREEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        brpu_pkg::REG_FORMAT:    cfg.fmt       <= cfg_data[brpu_pkg::FMT_W-1:0];
        brpu_pkg::REG_ROW_WIDTH: cfg.row_width <= cfg_data[brpu_pkg::ROW_W-1:0];
        brpu_pkg::REG_SCREEN:    cfg.screen    <= cfg_data[brpu_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  brpu_gather u_gather (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && mode),
    .data_byte (data_byte),
    .cfg       (cfg),
    .pix       (pix)
  );

  brpu_ram #(
    .WIDTH (brpu_pkg::PAL_W),
    .DEPTH (brpu_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[brpu_pkg::PAL_AW-1:0]),
    .wdata (palette_color),
    .re    (pix.done),
    .raddr (pix.full[brpu_pkg::PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= pix.done;
    end else if (out_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.done) begin
      p1_full   <= pix.full;
      p1_last   <= pix.last;
      p1_fmt    <= cfg.fmt;
      p1_screen <= cfg.screen;
      p1_pal_ok <= 9'(pix.full[7:0]) < 9'(brpu_pkg::PALETTE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p1_valid) begin
      pixel_word  <= brpu_pkg::decode_pixel(p1_fmt, p1_full,
                                            p1_pal_ok ? pal_rdata : '0)
                     & brpu_pkg::screen_mask(p1_screen);
      last_in_row <= p1_last;
    end
  end

endmodule

// ===== src/brpu_checker.sv =====
// Port-level checker of the bitmap row unpacker, bound to the top level.
// Depends on brpu_pkg and bmp_row_pixel_unpacker_defines.svh.
`include "bmp_row_pixel_unpacker_defines.svh"

module brpu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        mode,
  input logic [7:0]                  palette_index,
  input logic [23:0]                 palette_color,
  input logic [7:0]                  data_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [31:0]                 pixel_word,
  input logic                        last_in_row,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [brpu_pkg::IDX_W-1:0]  cfg_index,
  input logic [brpu_pkg::CFG_DW-1:0] cfg_data
);

  // A held result keeps its payload until it is taken.
  `BRPU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(pixel_word) && $stable(last_in_row))

  // Input is only held back when the output itself is blocked.
  `BRPU_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)

  // A new pixel always follows an input transfer, through the decode stage and the output register.
  `BRPU_ASSERT(a_out_source, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))

  // No result is shown in the first cycle after reset.
  `BRPU_ASSERT(a_reset_empty, $past(rst) |-> !out_valid)

endmodule

bind bmp_row_pixel_unpacker brpu_checker u_brpu_checker (.*);
